[sv/iacl_pkg.sv]
// ----------------------------------------------------------------------------
// iacl_pkg
// Shared constants, codes and types of the IP access rule checker.
// ----------------------------------------------------------------------------
package iacl_pkg;

  localparam int RULES_PER_LIST = 16;
  localparam int METHOD_COUNT   = 16;
  localparam int ENTRY_COUNT    = 2 * RULES_PER_LIST;
  localparam int ENTRY_AW       = $clog2(ENTRY_COUNT);

  localparam int SLOT_W   = 4;
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 32;
  localparam int METHOD_W = 4;
  localparam int MASK_W   = 16;
  localparam int ORDER_W  = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic LIST_DENY  = 1'b0;
  localparam logic LIST_ALLOW = 1'b1;

  localparam logic ST_WRITTEN  = 1'b0;
  localparam logic ST_ANSWERED = 1'b1;

  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ALL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NET   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

  localparam logic [ADDR_W-1:0] NET_NONE = '1;

  localparam logic [1:0] ORD_DENY_FIRST  = 2'd0;
  localparam logic [1:0] ORD_ALLOW_FIRST = 2'd1;
  localparam logic [1:0] ORD_BOTH_NEEDED = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] net;
    logic [ADDR_W-1:0] mask;
    logic [MASK_W-1:0] methods;
  } rule_t;

  typedef struct packed {
    logic                we;
    logic [ENTRY_AW-1:0] waddr;
    rule_t               wrule;
    logic                re;
    logic [ENTRY_AW-1:0] raddr;
  } store_cmd_t;

endpackage

[sv/iacl_if.sv]
// ----------------------------------------------------------------------------
// iacl_if
// Valid/ready channels of the IP access rule checker: request, response, cfg.
// ----------------------------------------------------------------------------
interface iacl_req_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic                              list_sel;
  logic [iacl_pkg::SLOT_W-1:0]       rule_slot;
  logic [iacl_pkg::KIND_W-1:0]       rule_kind;
  logic [iacl_pkg::ADDR_W-1:0]       rule_net;
  logic [iacl_pkg::ADDR_W-1:0]       rule_mask;
  logic [iacl_pkg::MASK_W-1:0]       rule_methods;
  logic [iacl_pkg::ADDR_W-1:0]       client_addr;
  logic [iacl_pkg::METHOD_W-1:0]     method;

  modport source (
    output valid, opcode, list_sel, rule_slot, rule_kind, rule_net, rule_mask,
           rule_methods, client_addr, method,
    input  ready
  );
  modport sink (
    input  valid, opcode, list_sel, rule_slot, rule_kind, rule_net, rule_mask,
           rule_methods, client_addr, method,
    output ready
  );
endinterface

interface iacl_rsp_if;
  logic valid;
  logic ready;
  logic permitted;
  logic status;

  modport source (output valid, permitted, status, input ready);
  modport sink   (input valid, permitted, status, output ready);
endinterface

interface iacl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [iacl_pkg::ORDER_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[sv/iacl_rule_store.sv]
// ----------------------------------------------------------------------------
// iacl_rule_store
// Rule memory, deny list then allow list; per-entry valid bits clear on reset.
// ----------------------------------------------------------------------------
module iacl_rule_store (
  input  logic                 clk,
  input  logic                 rst,
  input  iacl_pkg::store_cmd_t cmd,
  output iacl_pkg::rule_t      rd_rule
);

  iacl_pkg::rule_t                    mem [iacl_pkg::ENTRY_COUNT];
  logic [iacl_pkg::ENTRY_COUNT-1:0]   valid;
  iacl_pkg::rule_t                    rd_q;
  logic                               rd_valid;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wrule;
    end
    if (cmd.re) begin
      rd_q <= mem[cmd.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.we) begin
        valid[cmd.waddr] <= 1'b1;
      end
      if (cmd.re) begin
        rd_valid <= valid[cmd.raddr];
      end
    end
  end

  // never-written entry reads as an empty rule
  assign rd_rule = rd_valid ? rd_q : '0;

endmodule

[sv/iacl_match.sv]
// ----------------------------------------------------------------------------
// iacl_match
// Shared rule comparator: one stored rule against the client address/method.
// ----------------------------------------------------------------------------
module iacl_match (
  input  iacl_pkg::rule_t                rule,
  input  logic [iacl_pkg::ADDR_W-1:0]    addr,
  input  logic [iacl_pkg::METHOD_W-1:0]  method,
  output logic                           hit
);

  logic en;
  logic net_hit;

  always_comb begin
    en = 1'b0;
    if ({1'b0, method} < (iacl_pkg::METHOD_W+1)'(iacl_pkg::MASK_W)) begin
      en = rule.methods[method];
    end
    net_hit = (rule.kind == iacl_pkg::KIND_NET) && (rule.net != iacl_pkg::NET_NONE) &&
              ((addr & rule.mask) == rule.net);
    hit = en && ((rule.kind == iacl_pkg::KIND_ALL) || net_hit);
  end

endmodule

[sv/iacl_seq.sv]
// ----------------------------------------------------------------------------
// iacl_seq
// Sequencer: takes request words, writes rules, walks both lists through the
// shared comparator and holds the response word.
// ----------------------------------------------------------------------------
module iacl_seq (
  input  logic                          clk,
  input  logic                          rst,
  iacl_req_if.sink                      req,
  iacl_rsp_if.source                    rsp,
  input  logic [iacl_pkg::ORDER_W-1:0]  order_per_method,
  output iacl_pkg::store_cmd_t          cmd,
  input  iacl_pkg::rule_t               rd_rule
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_RESP} state_t;

  localparam logic [iacl_pkg::ENTRY_AW-1:0] LAST_IDX =
    iacl_pkg::ENTRY_AW'(iacl_pkg::ENTRY_COUNT - 1);
  localparam logic [iacl_pkg::ENTRY_AW-1:0] ALLOW_BASE =
    iacl_pkg::ENTRY_AW'(iacl_pkg::RULES_PER_LIST);

  state_t                          state;
  logic [iacl_pkg::ENTRY_AW-1:0]   idx;
  logic                            rd_pend;
  logic                            rd_allow;
  logic                            deny_hit;
  logic                            allow_hit;
  logic [iacl_pkg::ADDR_W-1:0]     addr;
  logic [iacl_pkg::METHOD_W-1:0]   method;
  logic                            is_check;
  logic                            out_valid;
  logic                            out_permitted;
  logic                            out_status;

  logic                            accept;
  logic                            slot_ok;
  logic                            hit;
  logic [1:0]                      ord;
  logic                            method_ok;
  logic                            ok;

  iacl_match u_match (
    .rule   (rd_rule),
    .addr   (addr),
    .method (method),
    .hit    (hit)
  );

  assign req.ready     = (state == S_IDLE);
  assign accept        = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.permitted = out_permitted;
  assign rsp.status    = out_status;

  always_comb begin
    slot_ok = {1'b0, req.rule_slot} < (iacl_pkg::SLOT_W+1)'(iacl_pkg::RULES_PER_LIST);
    cmd.we    = accept && (req.opcode == iacl_pkg::OP_WRITE) && slot_ok;
    cmd.waddr = (req.list_sel == iacl_pkg::LIST_ALLOW) ?
                ALLOW_BASE + iacl_pkg::ENTRY_AW'(req.rule_slot) :
                iacl_pkg::ENTRY_AW'(req.rule_slot);
    cmd.wrule.kind    = req.rule_kind;
    cmd.wrule.net     = req.rule_net & req.rule_mask;
    cmd.wrule.mask    = req.rule_mask;
    cmd.wrule.methods = req.rule_methods;
    cmd.re    = (state == S_WALK);
    cmd.raddr = idx;
  end

  always_comb begin
    method_ok = {1'b0, method} < (iacl_pkg::METHOD_W+1)'(iacl_pkg::METHOD_COUNT);
    ord = 2'(order_per_method >> {method, 1'b0});
    case (ord)
      iacl_pkg::ORD_DENY_FIRST:  ok = allow_hit || !deny_hit;
      iacl_pkg::ORD_ALLOW_FIRST: ok = allow_hit && !deny_hit;
      default:                   ok = allow_hit && !deny_hit;
    endcase
    ok = ok && method_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      rd_pend   <= 1'b0;
      rd_allow  <= 1'b0;
      deny_hit  <= 1'b0;
      allow_hit <= 1'b0;
      is_check  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      rd_pend  <= (state == S_WALK);
      rd_allow <= (idx >= ALLOW_BASE);
      if (rd_pend && hit) begin
        if (rd_allow) begin
          allow_hit <= 1'b1;
        end else begin
          deny_hit <= 1'b1;
        end
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            addr      <= req.client_addr;
            method    <= req.method;
            is_check  <= (req.opcode == iacl_pkg::OP_CHECK);
            deny_hit  <= 1'b0;
            allow_hit <= 1'b0;
            idx       <= '0;
            state     <= (req.opcode == iacl_pkg::OP_CHECK) ? S_WALK : S_RESP;
          end
        end
        S_WALK: begin
          idx <= idx + 1'b1;
          if (idx == LAST_IDX) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || rsp.ready) begin
            out_valid     <= 1'b1;
            out_permitted <= is_check && ok;
            out_status    <= is_check ? iacl_pkg::ST_ANSWERED : iacl_pkg::ST_WRITTEN;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/ip_access_rule_check_top.sv]
// ----------------------------------------------------------------------------
// ip_access_rule_check_top
// IP access filter with a deny and an allow rule list and per-method order.
//
// req carries one word per item: opcode 0 writes a rule (list_sel, rule_slot,
// rule_kind, rule_net, rule_mask, rule_methods), opcode 1 checks client_addr
// and method. rsp returns one word per item: permitted and status.
// cfg writes order_per_method, two bits per method; write it only while idle.
// A write goes from accept to the response step; a check first walks the rule
// memory, then a drain step, then the response step. The next word is taken
// once the answer is registered. One comparator reads the 32-entry memory one
// entry per cycle, then deny/allow hits are combined by the method's order.
// req is ready only while the sequencer is idle, so one item at a time.
// A stalled rsp holds its word; req still takes the next word and works it,
// and that item waits in its response step until the held word is taken.
// Reset clears the order register and marks every rule slot empty; no
// clearing pass is needed, the block is ready right after reset.
// ----------------------------------------------------------------------------
module ip_access_rule_check_top (
  input  logic        clk,
  input  logic        rst,
  iacl_req_if.sink    req,
  iacl_rsp_if.source  rsp,
  iacl_cfg_if.sink    cfg
);

  logic [iacl_pkg::ORDER_W-1:0] order_per_method;
  iacl_pkg::store_cmd_t         cmd;
  iacl_pkg::rule_t              rd_rule;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_per_method <= '0;
    end else if (cfg.valid && cfg.ready) begin
      order_per_method <= cfg.data;
    end
  end

  iacl_rule_store u_store (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .rd_rule (rd_rule)
  );

  iacl_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .req              (req),
    .rsp              (rsp),
    .order_per_method (order_per_method),
    .cmd              (cmd),
    .rd_rule          (rd_rule)
  );

endmodule
